@@ hdl/imh_pkg.sv @@
// Package: request/response payload types and code constants for the indexed max-heap.
`default_nettype none
package imh_pkg;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_POP    = 2'd2;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_MISS  = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] key_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] top_value;
        logic               is_empty;
        logic [6:0]         entry_count;
    } resp_t;

endpackage
`default_nettype wire

@@ hdl/imh_cmp.sv @@
// Shared signed key comparator: less-than and equality.
`default_nettype none
module imh_cmp #(
    parameter int KEY_BITS = 32
) (
    input  wire logic signed [KEY_BITS-1:0] a,
    input  wire logic signed [KEY_BITS-1:0] b,
    output logic                            lt,
    output logic                            eq
);

    assign lt = (a < b);
    assign eq = (a == b);

endmodule
`default_nettype wire

@@ hdl/imh_core.sv @@
// Heap sequencer: key store, linear search and hole-based sift up/down.
`default_nettype none
module imh_core #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [1:0]                 start_mode,
    input  wire logic signed [KEY_BITS-1:0] start_key,
    output logic                            idle,
    output logic                            res_valid,
    input  wire logic                       res_take,
    output imh_pkg::resp_t                  res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_SRCH   = 11'b000_0000_0010,
        ST_LASTW  = 11'b000_0000_0100,
        ST_UP_RD  = 11'b000_0000_1000,
        ST_UP_CMP = 11'b000_0001_0000,
        ST_DN_RL  = 11'b000_0010_0000,
        ST_DN_CL  = 11'b000_0100_0000,
        ST_DN_CR  = 11'b000_1000_0000,
        ST_DN_DEC = 11'b001_0000_0000,
        ST_DONE   = 11'b010_0000_0000,
        ST_SPARE  = 11'b100_0000_0000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [CW-1:0]              scan_reg, scan_next;
    logic [AW-1:0]              chk_reg, chk_next;
    logic                       pend_reg, pend_next;
    logic [AW-1:0]              pos_reg, pos_next;
    logic [AW-1:0]              best_reg, best_next;
    logic signed [KEY_BITS-1:0] key_reg, key_next;
    logic signed [KEY_BITS-1:0] cur_reg, cur_next;
    logic signed [KEY_BITS-1:0] bestv_reg, bestv_next;
    logic signed [KEY_BITS-1:0] top_reg;
    logic [1:0]                 status_reg, status_next;

    logic signed [KEY_BITS-1:0] heap_mem [CAPACITY];
    logic signed [KEY_BITS-1:0] rd_data_reg;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic signed [KEY_BITS-1:0] wr_data;

    logic signed [KEY_BITS-1:0] cmp_a, cmp_b;
    logic                       cmp_lt, cmp_eq;

    logic [AW+1:0]              lc_idx, rc_idx, cnt_ext;
    logic [AW-1:0]              parent_idx, last_idx;

    imh_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt),
        .eq (cmp_eq)
    );

    assign lc_idx     = (AW+2)'({pos_reg, 1'b1});
    assign rc_idx     = (AW+2)'({pos_reg, 1'b0}) + (AW+2)'(2);
    assign cnt_ext    = (AW+2)'(cnt_reg);
    assign parent_idx = AW'((pos_reg - AW'(1)) >> 1);
    assign last_idx   = AW'(cnt_reg - CW'(1));

    always_comb
    begin
        cmp_a = cur_reg;
        cmp_b = rd_data_reg;
        case (state_reg)
            ST_SRCH:
            begin
                cmp_a = rd_data_reg;
                cmp_b = key_reg;
            end
            ST_LASTW:
            begin
                cmp_a = rd_data_reg;
                cmp_b = key_reg;
            end
            ST_DN_CR:
            begin
                cmp_a = bestv_reg;
                cmp_b = rd_data_reg;
            end
            default:
            begin
                cmp_a = cur_reg;
                cmp_b = rd_data_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        scan_next   = scan_reg;
        chk_next    = chk_reg;
        pend_next   = pend_reg;
        pos_next    = pos_reg;
        best_next   = best_reg;
        key_next    = key_reg;
        cur_next    = cur_reg;
        bestv_next  = bestv_reg;
        status_next = status_reg;
        rd_en       = 1'b0;
        rd_addr     = pos_reg;
        wr_en       = 1'b0;
        wr_addr     = pos_reg;
        wr_data     = cur_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    status_next = imh_pkg::STATUS_DONE;
                    scan_next   = '0;
                    pend_next   = 1'b0;
                    key_next    = start_key;
                    if (start_mode == imh_pkg::MODE_ADD)
                    begin
                        if (cnt_reg >= CW'(CAPACITY))
                        begin
                            status_next = imh_pkg::STATUS_FULL;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            pos_next   = cnt_reg[AW-1:0];
                            cur_next   = start_key;
                            cnt_next   = cnt_reg + CW'(1);
                            state_next = ST_UP_RD;
                        end
                    end
                    else if (start_mode == imh_pkg::MODE_REMOVE)
                    begin
                        state_next = ST_SRCH;
                    end
                    else if (cnt_reg == '0)
                    begin
                        status_next = imh_pkg::STATUS_MISS;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        key_next   = top_reg;
                        state_next = ST_SRCH;
                    end
                end
            end
            ST_SRCH:
            begin
                // reads are pipelined: the data seen now belongs to chk_reg
                if (pend_reg && cmp_eq)
                begin
                    pos_next  = chk_reg;
                    cnt_next  = cnt_reg - CW'(1);
                    pend_next = 1'b0;
                    if (chk_reg == last_idx)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = last_idx;
                        state_next = ST_LASTW;
                    end
                end
                else if (scan_reg < cnt_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg[AW-1:0];
                    chk_next  = scan_reg[AW-1:0];
                    scan_next = scan_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    status_next = imh_pkg::STATUS_MISS;
                    pend_next   = 1'b0;
                    state_next  = ST_DONE;
                end
            end
            ST_LASTW:
            begin
                cur_next   = rd_data_reg;
                state_next = cmp_lt ? ST_DN_RL : ST_UP_RD;
            end
            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = parent_idx;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                if (cmp_lt)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    // parent moves down into the hole
                    wr_en      = 1'b1;
                    wr_data    = rd_data_reg;
                    pos_next   = parent_idx;
                    state_next = ST_UP_RD;
                end
            end
            ST_DN_RL:
            begin
                if (lc_idx >= cnt_ext)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = lc_idx[AW-1:0];
                    state_next = ST_DN_CL;
                end
            end
            ST_DN_CL:
            begin
                best_next  = pos_reg;
                bestv_next = cur_reg;
                if (cmp_lt)
                begin
                    best_next  = lc_idx[AW-1:0];
                    bestv_next = rd_data_reg;
                end
                if (rc_idx < cnt_ext)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = rc_idx[AW-1:0];
                    state_next = ST_DN_CR;
                end
                else
                begin
                    state_next = ST_DN_DEC;
                end
            end
            ST_DN_CR:
            begin
                if (cmp_lt)
                begin
                    best_next  = rc_idx[AW-1:0];
                    bestv_next = rd_data_reg;
                end
                state_next = ST_DN_DEC;
            end
            ST_DN_DEC:
            begin
                wr_en = 1'b1;
                if (best_reg == pos_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    wr_data    = bestv_reg;
                    pos_next   = best_reg;
                    state_next = ST_DN_RL;
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg   <= scan_next;
        chk_reg    <= chk_next;
        pos_reg    <= pos_next;
        best_reg   <= best_next;
        key_reg    <= key_next;
        cur_reg    <= cur_next;
        bestv_reg  <= bestv_next;
        status_reg <= status_next;
        if (wr_en && (wr_addr == '0))
        begin
            top_reg <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= heap_mem[rd_addr];
        end
    end

    logic signed [KEY_BITS-1:0] key_min;
    logic signed [KEY_BITS-1:0] top_sel;
    logic signed [63:0]         top_wide;

    assign key_min  = {1'b1, {(KEY_BITS-1){1'b0}}};
    assign top_sel  = (cnt_reg == '0) ? key_min : top_reg;
    assign top_wide = 64'(top_sel);

    assign idle                = (state_reg == ST_IDLE);
    assign res_valid           = (state_reg == ST_DONE);
    assign res.status          = status_reg;
    assign res.top_value       = top_wide[31:0];
    assign res.is_empty        = (cnt_reg == '0);
    assign res.entry_count     = 7'(cnt_reg);

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("heap count exceeds capacity");

    a_full_only_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && status_reg == imh_pkg::STATUS_FULL) |-> (cnt_reg == CW'(CAPACITY)))
        else $error("full status while heap has room");

    a_up_pos_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP_RD || state_reg == ST_DN_RL) |-> (CW'(pos_reg) < cnt_reg))
        else $error("sift position outside live slots");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_take) |=> (res_valid && $stable(cnt_reg)))
        else $error("result dropped before transfer");
`endif

endmodule
`default_nettype wire

@@ hdl/indexed_max_heap.sv @@
// Indexed max-heap top level: request intake, key widening and response register.
//
// Requests arrive on in_valid/in_ready with in_data (mode, key_value); each
// request produces exactly one response on out_valid/out_ready with out_data
// (status, top_value, is_empty, entry_count). One request is in work at a
// time; in_ready is high only while the sequencer is idle.
// Steps per request, all sequenced through one shared comparator:
//   add:    the new key climbs from the last slot, at most log2(CAPACITY) levels.
//   remove: a linear search of the n live slots, then a fetch of the last
//           entry, then sift up or sift down.
//   pop:    as remove, with the search ending at slot 0.
// The response sits in an output register; the next request is taken as soon
// as the sequencer hands its result over, even if the receiver stalls, and a
// further result waits in the sequencer until the register frees.
// Reset (rst_n low, asynchronous) empties the heap; the key store itself is
// not cleared, as only live slots are ever read.
`default_nettype none
module indexed_max_heap #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire imh_pkg::req_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output imh_pkg::resp_t      out_data
);

    logic                       core_idle;
    logic                       res_valid;
    logic                       res_take;
    imh_pkg::resp_t             res;
    logic signed [63:0]         key_wide;
    logic signed [KEY_BITS-1:0] key_in;
    logic                       out_valid_reg;
    imh_pkg::resp_t             out_data_reg;

    assign key_wide = 64'(in_data.key_value);
    assign key_in   = key_wide[KEY_BITS-1:0];
    assign in_ready = core_idle;
    assign res_take = res_valid && (!out_valid_reg || out_ready);

    imh_core #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_valid && core_idle),
        .start_mode (in_data.mode),
        .start_key  (key_in),
        .idle       (core_idle),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

@@ tb/sv/indexed_max_heap_tb.sv @@
// Testbench for indexed_max_heap: directed table, capacity fill, random requests; checked by a heap predictor.
`timescale 1ns / 100ps
`default_nettype none
module indexed_max_heap_tb;

    localparam int CAP = 64;
    localparam int RANDOM_REQS = 500;
    localparam int DIR_ROWS = 21;

    typedef struct {
        logic [1:0]         mode;
        logic signed [31:0] key;
        logic               has_exp;
        logic [1:0]         exp_status;
        logic [6:0]         exp_count;
    } dir_row_t;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    imh_pkg::req_t   in_data;
    logic            out_valid;
    logic            out_ready;
    imh_pkg::resp_t  out_data;

    logic signed [31:0] heap_keys [CAP];
    int                 heap_size;
    imh_pkg::resp_t     pending_resp [$];
    int                 error_count;

    indexed_max_heap i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void swap_keys(int a, int b);
        logic signed [31:0] t;
        t = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = t;
    endfunction

    function automatic void climb(int pos);
        int up;
        while (pos > 0)
        begin
            up = (pos - 1) / 2;
            if (heap_keys[pos] < heap_keys[up])
                break;
            swap_keys(pos, up);
            pos = up;
        end
    endfunction

    function automatic void sink(int pos);
        int best;
        while (1'b1)
        begin
            best = pos;
            if (2 * pos + 1 < heap_size && heap_keys[best] < heap_keys[2 * pos + 1])
                best = 2 * pos + 1;
            if (2 * pos + 2 < heap_size && heap_keys[best] < heap_keys[2 * pos + 2])
                best = 2 * pos + 2;
            if (best == pos)
                break;
            swap_keys(pos, best);
            pos = best;
        end
    endfunction

    function automatic bit take_key(logic signed [31:0] key);
        int pos;
        int last;
        for (pos = 0; pos < heap_size; pos++)
            if (heap_keys[pos] == key)
                break;
        if (pos >= heap_size)
            return 1'b0;
        last = heap_size - 1;
        heap_keys[pos] = heap_keys[last];
        heap_size = last;
        if (pos == last)
            return 1'b1;
        if (heap_keys[pos] < key)
            sink(pos);
        else
            climb(pos);
        return 1'b1;
    endfunction

    function automatic imh_pkg::resp_t heap_apply(imh_pkg::req_t req);
        imh_pkg::resp_t r;
        r.status = imh_pkg::STATUS_DONE;
        if (req.mode == imh_pkg::MODE_ADD)
        begin
            if (heap_size >= CAP)
                r.status = imh_pkg::STATUS_FULL;
            else
            begin
                heap_keys[heap_size] = req.key_value;
                heap_size++;
                climb(heap_size - 1);
            end
        end
        else if (req.mode == imh_pkg::MODE_REMOVE)
        begin
            if (!take_key(req.key_value))
                r.status = imh_pkg::STATUS_MISS;
        end
        else if (heap_size == 0)
            r.status = imh_pkg::STATUS_MISS;
        else
            void'(take_key(heap_keys[0]));
        r.top_value   = heap_size ? heap_keys[0] : 32'sh8000_0000;
        r.is_empty    = (heap_size == 0);
        r.entry_count = 7'(heap_size);
        return r;
    endfunction

    // One request: optional idle gap, then hold valid until the transfer.
    task automatic send_req(logic [1:0] mode, logic signed [31:0] key, int gap);
        imh_pkg::req_t  req;
        imh_pkg::resp_t exp_resp;
        req.mode      = mode;
        req.key_value = key;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        exp_resp     = heap_apply(req);
        pending_resp = {pending_resp, exp_resp};
    endtask

    task automatic drain_wait();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_resp.size() != 0);
    endtask

    // Checker
    always @(posedge clk)
    begin
        imh_pkg::resp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_resp.size() == 0)
            begin
                $display("%0t: response with none expected: %p", $time, out_data);
                error_count++;
            end
            else
            begin
                want = pending_resp.pop_front();
                if (out_data.status !== want.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, want.status,
                             out_data.status);
                    error_count++;
                end
                if (out_data.top_value !== want.top_value)
                begin
                    $display("%0t: top_value exp %0d got %0d", $time, want.top_value,
                             out_data.top_value);
                    error_count++;
                end
                if (out_data.is_empty !== want.is_empty)
                begin
                    $display("%0t: is_empty exp %0d got %0d", $time, want.is_empty,
                             out_data.is_empty);
                    error_count++;
                end
                if (out_data.entry_count !== want.entry_count)
                begin
                    $display("%0t: entry_count exp %0d got %0d", $time, want.entry_count,
                             out_data.entry_count);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall pattern: alternating runs of always-ready and random stalls
    initial
    begin
        int phase;
        out_ready = 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            phase = (phase + 1) % 600;
            if (phase < 150)
                out_ready <= 1'b1;
            else if (phase < 400)
                out_ready <= ($urandom_range(0, 3) != 0);
            else
                out_ready <= ($urandom_range(0, 9) < 3);
        end
    end

    initial
    begin
        dir_row_t dir_table [DIR_ROWS];
        int       mult;
        int       burst;
        int       gap;
        int       r;
        logic signed [31:0] key;
        logic [1:0] mode;

        error_count = 0;
        heap_size   = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;

        // mode, key, has expected, status, count
        dir_table = '{
            '{imh_pkg::MODE_POP,    32'sd0,         1'b1, imh_pkg::STATUS_MISS, 7'd0},
            '{imh_pkg::MODE_REMOVE, 32'sd5,         1'b1, imh_pkg::STATUS_MISS, 7'd0},
            '{2'd3,                 32'sd0,         1'b1, imh_pkg::STATUS_MISS, 7'd0},
            '{imh_pkg::MODE_ADD,    32'sh8000_0000, 1'b1, imh_pkg::STATUS_DONE, 7'd1},
            '{imh_pkg::MODE_ADD,    32'sh7fff_ffff, 1'b1, imh_pkg::STATUS_DONE, 7'd2},
            '{imh_pkg::MODE_ADD,    -32'sd1,        1'b0, 0, 0},
            '{imh_pkg::MODE_ADD,    32'sd0,         1'b0, 0, 0},
            '{imh_pkg::MODE_ADD,    32'sd7,         1'b0, 0, 0},
            '{imh_pkg::MODE_ADD,    32'sd7,         1'b0, 0, 0},
            '{imh_pkg::MODE_ADD,    32'sd3,         1'b0, 0, 0},
            '{imh_pkg::MODE_ADD,    32'sd7,         1'b0, 0, 0},
            '{imh_pkg::MODE_REMOVE, 32'sd7,         1'b0, 0, 0},
            '{imh_pkg::MODE_REMOVE, 32'sd99,        1'b1, imh_pkg::STATUS_MISS, 7'd7},
            '{imh_pkg::MODE_REMOVE, 32'sh7fff_ffff, 1'b0, 0, 0},
            '{imh_pkg::MODE_REMOVE, 32'sd7,         1'b0, 0, 0},
            '{imh_pkg::MODE_POP,    32'sd0,         1'b0, 0, 0},
            '{2'd3,                 32'sd0,         1'b0, 0, 0},
            '{imh_pkg::MODE_REMOVE, 32'sh8000_0000, 1'b0, 0, 0},
            '{imh_pkg::MODE_POP,    32'sd0,         1'b0, 0, 0},
            '{imh_pkg::MODE_POP,    32'sd0,         1'b1, imh_pkg::STATUS_DONE, 7'd0},
            '{imh_pkg::MODE_POP,    32'sd0,         1'b1, imh_pkg::STATUS_MISS, 7'd0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
        begin
            send_req(dir_table[i].mode, dir_table[i].key, $urandom_range(0, 2));
            if (dir_table[i].has_exp
                && (pending_resp[$].status !== dir_table[i].exp_status
                    || pending_resp[$].entry_count !== dir_table[i].exp_count))
            begin
                $display("%0t: table row %0d exp status %0d count %0d, got %0d %0d", $time,
                         i, dir_table[i].exp_status, dir_table[i].exp_count,
                         pending_resp[$].status, pending_resp[$].entry_count);
                error_count++;
            end
        end
        drain_wait();

        // Fill to capacity with duplicates, hit the full case, then empty by pops
        for (int i = 0; i < CAP + 2; i++)
            send_req(imh_pkg::MODE_ADD, 32'($urandom_range(0, 20)) - 10, 0);
        for (int i = 0; i < CAP + 1; i++)
            send_req(imh_pkg::MODE_POP, $urandom, 0);

        // Random bursts; keys from a narrow pool so removes usually hit
        r = 0;
        while (r < RANDOM_REQS)
        begin
            burst = $urandom_range(1, 12);
            gap   = $urandom_range(0, 6);
            if (r == RANDOM_REQS / 2)
                drain_wait();
            for (int b = 0; b < burst && r < RANDOM_REQS; b++)
            begin
                mult = $urandom_range(0, 99);
                if (mult < 3)
                    key = $urandom;
                else if (mult < 6)
                    key = (mult == 3) ? 32'sh7fff_ffff : 32'sh8000_0000;
                else
                    key = 32'($urandom_range(0, 30)) - 15;
                // bias toward adds while small, removes while large
                mult = $urandom_range(0, 99);
                if (mult < 2)
                    mode = 2'd3;
                else if (mult < (heap_size < 40 ? 55 : 30))
                    mode = imh_pkg::MODE_ADD;
                else if (mult < 80)
                    mode = imh_pkg::MODE_REMOVE;
                else
                    mode = imh_pkg::MODE_POP;
                send_req(mode, key, (b == 0) ? gap : 0);
                r++;
            end
        end

        drain_wait();
        repeat (200) @(posedge clk);
        if (error_count == 0 && pending_resp.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
hdl/imh_pkg.sv
hdl/imh_cmp.sv
hdl/imh_core.sv
hdl/indexed_max_heap.sv
tb/sv/indexed_max_heap_tb.sv
